@@ design/wsat_pkg.sv @@
// wsat_pkg: shared widths, status codes, register indexes and helper functions
// for the local search engine. No dependencies.
package wsat_pkg;

   localparam int LIT_W      = 10;
   localparam int STATUS_W   = 3;
   localparam int NUMC_W     = 11;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [STATUS_W-1:0] ST_ACCEPTED   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_TOO_MANY   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_TOO_LONG   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_SAT        = 3'd3;
   localparam logic [STATUS_W-1:0] ST_OUT_OF_TIME = 3'd4;
   localparam logic [STATUS_W-1:0] ST_MISMATCH   = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_VARS    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_CLAUSES = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_TRIES   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_FLIPS   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NOISE       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED        = 3'd5;

   localparam logic [8:0]  RST_NUM_VARS    = 9'd1;
   localparam logic [10:0] RST_NUM_CLAUSES = 11'd1;
   localparam logic [15:0] RST_MAX_TRIES   = 16'd5;
   localparam logic [19:0] RST_MAX_FLIPS   = 20'd100;
   localparam logic [15:0] RST_NOISE       = 16'd37355;
   localparam logic [31:0] RST_SEED        = 32'd1;

   function automatic logic [31:0] xorshift(logic [31:0] s);
      logic [31:0] x;
      x = s ^ (s << 13);
      x = x ^ (x >> 17);
      x = x ^ (x << 5);
      return x;
   endfunction

   function automatic logic [LIT_W-1:0] lit_mag(logic [LIT_W-1:0] l);
      logic [LIT_W-1:0] neg;
      neg = LIT_W'(~l + 1'b1);
      return l[LIT_W-1] ? neg : l;
   endfunction

endpackage

@@ design/walksat_local_search_engine_top.sv @@
// walksat_local_search_engine_top: clause loader and local search sequencer
// with clause, length, assignment and unsat-list memories. Uses wsat_pkg.
//
// channel   ports                                  handshake
// request   req_action, req_literal                start & !busy
// response  rsp_status, rsp_model_word, ...        rsp_strobe, one cycle
// config    csr_index, csr_wdata                   csr_we
//
// a load request answers in the next cycle and another may follow at once.
// a start request runs the search: each clause evaluation reads the clause
// literal by literal, a full clause pass per flip, a pass per literal for the greedy
// break counts, a bit-serial division per random pick; the model dump is sent
// as 64-bit words. synchronous reset restores register defaults; no clearing
// pass. the receiver cannot stall, so every response is shown once.
module walksat_local_search_engine_top
   import wsat_pkg::*;
#(
   parameter int MAX_VARS       = 256,
   parameter int MAX_CLAUSES    = 1024,
   parameter int MAX_CLAUSE_LEN = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_action,
   input  logic signed [LIT_W-1:0] req_literal,
   output logic                    rsp_strobe,
   output logic [STATUS_W-1:0]     rsp_status,
   output logic [63:0]             rsp_model_word,
   output logic [1:0]              rsp_word_index,
   output logic                    rsp_last,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   localparam int AW    = $clog2(MAX_VARS + 1);
   localparam int VW    = (AW > LIT_W) ? AW : LIT_W;
   localparam int CW    = $clog2(MAX_CLAUSES + 1);
   localparam int CIW   = $clog2(MAX_CLAUSES);
   localparam int NCW   = (CW > NUMC_W) ? CW : NUMC_W;
   localparam int LW    = $clog2(MAX_CLAUSE_LEN + 1);
   localparam int SDEPTH = MAX_CLAUSES * MAX_CLAUSE_LEN;
   localparam int SAW   = $clog2(SDEPTH);
   localparam int DVW   = (CW > LW) ? CW : LW;

   typedef enum logic [28:0] {
      S_IDLE    = 29'(1) << 0,
      S_TRY     = 29'(1) << 1,
      S_RAND    = 29'(1) << 2,
      S_FLIP    = 29'(1) << 3,
      S_GATH    = 29'(1) << 4,
      S_PICK    = 29'(1) << 5,
      S_DIV     = 29'(1) << 6,
      S_USEL    = 29'(1) << 7,
      S_USELW   = 29'(1) << 8,
      S_CLEN    = 29'(1) << 9,
      S_CLENW   = 29'(1) << 10,
      S_NOISE   = 29'(1) << 11,
      S_WDRAW   = 29'(1) << 12,
      S_WLIT    = 29'(1) << 13,
      S_WLITW   = 29'(1) << 14,
      S_GLIT    = 29'(1) << 15,
      S_GLITW   = 29'(1) << 16,
      S_BRK     = 29'(1) << 17,
      S_FLIPV   = 29'(1) << 18,
      S_FLIPW   = 29'(1) << 19,
      S_EV_LEN  = 29'(1) << 20,
      S_EV_LENW = 29'(1) << 21,
      S_EV_LIT  = 29'(1) << 22,
      S_EV_LITW = 29'(1) << 23,
      S_EV_VAL  = 29'(1) << 24,
      S_EV_END  = 29'(1) << 25,
      S_DRD     = 29'(1) << 26,
      S_DRDW    = 29'(1) << 27,
      S_DOUT    = 29'(1) << 28
   } state_type;

   // memories
   logic [LIT_W-1:0] cls_mem [SDEPTH];
   logic [LW-1:0]    len_mem [MAX_CLAUSES];
   logic             asg_mem [MAX_VARS + 1];
   logic [CIW-1:0]   uns_mem [MAX_CLAUSES];

   logic             cls_we;
   logic [SAW-1:0]   cls_waddr, cls_raddr;
   logic [LIT_W-1:0] cls_wdata, cls_rd_ff;
   logic             len_we;
   logic [CIW-1:0]   len_waddr, len_raddr;
   logic [LW-1:0]    len_wdata, len_rd_ff;
   logic             asg_we;
   logic [AW-1:0]    asg_waddr, asg_raddr;
   logic             asg_wdata, asg_rd_ff;
   logic             uns_we;
   logic [CIW-1:0]   uns_waddr, uns_raddr;
   logic [CIW-1:0]   uns_wdata, uns_rd_ff;

   always_ff @(posedge clock) begin
      if (cls_we) cls_mem[cls_waddr] <= cls_wdata;
      cls_rd_ff <= cls_mem[cls_raddr];
   end

   always_ff @(posedge clock) begin
      if (len_we) len_mem[len_waddr] <= len_wdata;
      len_rd_ff <= len_mem[len_raddr];
   end

   always_ff @(posedge clock) begin
      if (asg_we) asg_mem[asg_waddr] <= asg_wdata;
      asg_rd_ff <= asg_mem[asg_raddr];
   end

   always_ff @(posedge clock) begin
      if (uns_we) uns_mem[uns_waddr] <= uns_wdata;
      uns_rd_ff <= uns_mem[uns_raddr];
   end

   state_type state_ff, state_in;
   logic [8:0]  num_vars_ff, num_vars_in;
   logic [10:0] num_clauses_ff, num_clauses_in;
   logic [15:0] max_tries_ff, max_tries_in;
   logic [19:0] max_flips_ff, max_flips_in;
   logic [15:0] noise_ff, noise_in;
   logic [31:0] rng_ff, rng_in;
   logic [CW-1:0] load_cnt_ff, load_cnt_in;
   logic [LW-1:0] load_fill_ff, load_fill_in;
   logic        load_err_ff, load_err_in;
   logic [CW-1:0] m_ff, m_in, idx_ff, idx_in, n_ff, n_in;
   logic [CW-1:0] cnt_ff, cnt_in, best_ff, best_in;
   logic [15:0] try_ff, try_in;
   logic [19:0] flip_ff, flip_in;
   logic [VW-1:0] vctr_ff, vctr_in, cand_ff, cand_in, var_ff, var_in;
   logic [CIW-1:0] cur_c_ff, cur_c_in;
   logic [LW-1:0] cur_len_ff, cur_len_in, k2_ff, k2_in;
   logic [LW-1:0] ev_len_ff, ev_len_in, ev_k_ff, ev_k_in;
   logic        ev_sat_ff, ev_sat_in, ev_oth_ff, ev_oth_in;
   logic        mode_brk_ff, mode_brk_in, div_walk_ff, div_walk_in;
   logic [LIT_W-1:0] lit_ff, lit_in;
   logic [31:0] div_q_ff, div_q_in;
   logic [DVW-1:0] div_rem_ff, div_rem_in, div_d_ff, div_d_in;
   logic [4:0]  div_cnt_ff, div_cnt_in;
   logic [1:0]  w_ff, w_in;
   logic [6:0]  bit_ff, bit_in;
   logic [63:0] word_ff, word_in;
   logic        rsp_strobe_ff, rsp_strobe_in, rsp_last_ff, rsp_last_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [63:0] rsp_word_ff, rsp_word_in;
   logic [1:0]  rsp_widx_ff, rsp_widx_in;

   logic [31:0]    rng_nx;
   logic [VW-1:0]  nv, nvm1, ev_mag, rd_mag, dump_var;
   logic [1:0]     last_w;
   logic [NCW-1:0] cap;
   logic           accept, ev_val, lit_is_true, dump_ok;
   logic [DVW:0]   rem_sh;
   logic [DVW-1:0] rem_nx;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;
   assign rng_nx = xorshift(rng_ff);

   assign nv   = (VW'(num_vars_ff) > VW'(MAX_VARS)) ? VW'(MAX_VARS) : VW'(num_vars_ff);
   assign nvm1 = VW'(nv - 1'b1) >> 6;
   assign last_w = (nv == '0) ? 2'd0 : ((nvm1 > VW'(3)) ? 2'd3 : nvm1[1:0]);
   assign cap = (NCW'(num_clauses_ff) < NCW'(MAX_CLAUSES)) ? NCW'(num_clauses_ff)
                                                             : NCW'(MAX_CLAUSES);

   assign ev_mag      = VW'(lit_mag(lit_ff));
   assign rd_mag      = VW'(lit_mag(cls_rd_ff));
   assign ev_val      = (ev_mag != '0) && (ev_mag <= nv) && asg_rd_ff;
   assign lit_is_true = lit_ff[LIT_W-1] ? !ev_val : ev_val;
   assign dump_var    = VW'({w_ff, bit_ff[5:0]}) + VW'(1);
   assign dump_ok     = (dump_var <= nv);

   assign rem_sh = {div_rem_ff, div_q_ff[31]};
   assign rem_nx = (rem_sh >= {1'b0, div_d_ff}) ? DVW'(rem_sh - {1'b0, div_d_ff})
                                                 : DVW'(rem_sh);

   // read address steering
   always_comb begin
      unique case (state_ff)
         S_GLIT:  cls_raddr = SAW'(SAW'(cur_c_ff) * SAW'(MAX_CLAUSE_LEN) + SAW'(k2_ff));
         S_WLIT:  cls_raddr = SAW'(SAW'(cur_c_ff) * SAW'(MAX_CLAUSE_LEN) + SAW'(div_rem_ff));
         default: cls_raddr = SAW'(SAW'(idx_ff) * SAW'(MAX_CLAUSE_LEN) + SAW'(ev_k_ff));
      endcase
      len_raddr = (state_ff == S_CLEN) ? cur_c_ff : CIW'(idx_ff);
      uns_raddr = CIW'(div_rem_ff);
      unique case (state_ff)
         S_FLIPV: asg_raddr = AW'(var_ff);
         S_DRD:   asg_raddr = AW'(dump_var);
         default: asg_raddr = AW'(rd_mag);
      endcase
   end

   always_comb begin
      state_in = state_ff;
      num_vars_in = num_vars_ff;
      num_clauses_in = num_clauses_ff;
      max_tries_in = max_tries_ff;
      max_flips_in = max_flips_ff;
      noise_in = noise_ff;
      rng_in = rng_ff;
      load_cnt_in = load_cnt_ff;
      load_fill_in = load_fill_ff;
      load_err_in = load_err_ff;
      m_in = m_ff;
      idx_in = idx_ff;
      n_in = n_ff;
      cnt_in = cnt_ff;
      best_in = best_ff;
      try_in = try_ff;
      flip_in = flip_ff;
      vctr_in = vctr_ff;
      cand_in = cand_ff;
      var_in = var_ff;
      cur_c_in = cur_c_ff;
      cur_len_in = cur_len_ff;
      k2_in = k2_ff;
      ev_len_in = ev_len_ff;
      ev_k_in = ev_k_ff;
      ev_sat_in = ev_sat_ff;
      ev_oth_in = ev_oth_ff;
      mode_brk_in = mode_brk_ff;
      div_walk_in = div_walk_ff;
      lit_in = lit_ff;
      div_q_in = div_q_ff;
      div_rem_in = div_rem_ff;
      div_d_in = div_d_ff;
      div_cnt_in = div_cnt_ff;
      w_in = w_ff;
      bit_in = bit_ff;
      word_in = word_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_word_in = rsp_word_ff;
      rsp_widx_in = rsp_widx_ff;
      rsp_last_in = rsp_last_ff;
      cls_we = 1'b0;
      cls_waddr = SAW'(SAW'(load_cnt_ff) * SAW'(MAX_CLAUSE_LEN) + SAW'(load_fill_ff));
      cls_wdata = req_literal;
      len_we = 1'b0;
      len_waddr = CIW'(load_cnt_ff);
      len_wdata = load_fill_ff;
      asg_we = 1'b0;
      asg_waddr = AW'(vctr_ff);
      asg_wdata = rng_nx[0];
      uns_we = 1'b0;
      uns_waddr = CIW'(n_ff);
      uns_wdata = CIW'(idx_ff);

      if (csr_we) begin
         unique case (csr_index)
            CSR_NUM_VARS:    num_vars_in = csr_wdata[8:0];
            CSR_NUM_CLAUSES: num_clauses_in = csr_wdata[10:0];
            CSR_MAX_TRIES:   max_tries_in = csr_wdata[15:0];
            CSR_MAX_FLIPS:   max_flips_in = csr_wdata[19:0];
            CSR_NOISE:       noise_in = csr_wdata[15:0];
            CSR_SEED:        rng_in = (csr_wdata == '0) ? 32'd1 : csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = ST_ACCEPTED;
               rsp_word_in = '0;
               rsp_widx_in = '0;
               rsp_last_in = 1'b1;
               if (!req_action) begin
                  if (req_literal == '0) begin
                     if (load_fill_ff != '0) begin
                        len_we = 1'b1;
                        load_cnt_in = CW'(load_cnt_ff + 1'b1);
                        load_fill_in = '0;
                     end
                  end else if (NCW'(load_cnt_ff) >= cap) begin
                     rsp_status_in = ST_TOO_MANY;
                     load_err_in = 1'b1;
                  end else if (LW'(load_fill_ff) >= LW'(MAX_CLAUSE_LEN)) begin
                     rsp_status_in = ST_TOO_LONG;
                     load_err_in = 1'b1;
                  end else begin
                     cls_we = 1'b1;
                     load_fill_in = LW'(load_fill_ff + 1'b1);
                  end
               end else begin
                  load_cnt_in = '0;
                  load_fill_in = '0;
                  load_err_in = 1'b0;
                  if (load_err_ff || load_fill_ff != '0 ||
                      NCW'(load_cnt_ff) != NCW'(num_clauses_ff)) begin
                     rsp_status_in = ST_MISMATCH;
                  end else begin
                     rsp_strobe_in = 1'b0;
                     m_in = load_cnt_ff;
                     try_in = '0;
                     state_in = S_TRY;
                  end
               end
            end
         end
         S_TRY: begin
            if (try_ff == max_tries_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = ST_OUT_OF_TIME;
               rsp_word_in = '0;
               rsp_widx_in = '0;
               rsp_last_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               vctr_in = VW'(1);
               state_in = S_RAND;
            end
         end
         S_RAND: begin
            if (vctr_ff > nv) begin
               flip_in = '0;
               state_in = S_FLIP;
            end else begin
               asg_we = 1'b1;
               rng_in = rng_nx;
               vctr_in = VW'(vctr_ff + 1'b1);
            end
         end
         S_FLIP: begin
            if (flip_ff == max_flips_ff) begin
               try_in = 16'(try_ff + 1'b1);
               state_in = S_TRY;
            end else begin
               idx_in = '0;
               n_in = '0;
               state_in = S_GATH;
            end
         end
         S_GATH: begin
            if (idx_ff == m_ff) begin
               if (n_ff == '0) begin
                  w_in = '0;
                  bit_in = '0;
                  word_in = '0;
                  state_in = S_DRD;
               end else begin
                  state_in = S_PICK;
               end
            end else begin
               mode_brk_in = 1'b0;
               state_in = S_EV_LEN;
            end
         end
         S_PICK: begin
            rng_in = rng_nx;
            div_q_in = rng_nx;
            div_rem_in = '0;
            div_d_in = DVW'(n_ff);
            div_cnt_in = '0;
            div_walk_in = 1'b0;
            state_in = S_DIV;
         end
         S_DIV: begin
            div_rem_in = rem_nx;
            div_q_in = {div_q_ff[30:0], 1'b0};
            div_cnt_in = 5'(div_cnt_ff + 1'b1);
            if (div_cnt_ff == 5'd31) state_in = div_walk_ff ? S_WLIT : S_USEL;
         end
         S_USEL: state_in = S_USELW;
         S_USELW: begin
            cur_c_in = uns_rd_ff;
            state_in = S_CLEN;
         end
         S_CLEN: state_in = S_CLENW;
         S_CLENW: begin
            cur_len_in = len_rd_ff;
            state_in = S_NOISE;
         end
         S_NOISE: begin
            rng_in = rng_nx;
            if (rng_nx[15:0] < noise_ff) begin
               state_in = S_WDRAW;
            end else begin
               k2_in = '0;
               best_in = m_ff;
               state_in = S_GLIT;
            end
         end
         S_WDRAW: begin
            rng_in = rng_nx;
            div_q_in = rng_nx;
            div_rem_in = '0;
            div_d_in = DVW'(cur_len_ff);
            div_cnt_in = '0;
            div_walk_in = 1'b1;
            state_in = S_DIV;
         end
         S_WLIT: state_in = S_WLITW;
         S_WLITW: begin
            var_in = rd_mag;
            state_in = S_FLIPV;
         end
         S_GLIT: state_in = (k2_ff == cur_len_ff) ? S_FLIPV : S_GLITW;
         S_GLITW: begin
            cand_in = rd_mag;
            if (k2_ff == '0) var_in = rd_mag;
            idx_in = '0;
            cnt_in = '0;
            state_in = S_BRK;
         end
         S_BRK: begin
            if (idx_ff == m_ff) begin
               if (cnt_ff < best_ff) begin
                  best_in = cnt_ff;
                  var_in = cand_ff;
               end
               k2_in = LW'(k2_ff + 1'b1);
               state_in = S_GLIT;
            end else begin
               mode_brk_in = 1'b1;
               state_in = S_EV_LEN;
            end
         end
         S_FLIPV: begin
            if (var_ff != '0 && var_ff <= nv) begin
               state_in = S_FLIPW;
            end else begin
               flip_in = 20'(flip_ff + 1'b1);
               state_in = S_FLIP;
            end
         end
         S_FLIPW: begin
            asg_we = 1'b1;
            asg_waddr = AW'(var_ff);
            asg_wdata = ~asg_rd_ff;
            flip_in = 20'(flip_ff + 1'b1);
            state_in = S_FLIP;
         end
         S_EV_LEN: state_in = S_EV_LENW;
         S_EV_LENW: begin
            ev_len_in = len_rd_ff;
            ev_k_in = '0;
            ev_sat_in = 1'b0;
            ev_oth_in = 1'b0;
            state_in = S_EV_LIT;
         end
         S_EV_LIT: state_in = (ev_k_ff == ev_len_ff) ? S_EV_END : S_EV_LITW;
         S_EV_LITW: begin
            lit_in = cls_rd_ff;
            state_in = S_EV_VAL;
         end
         S_EV_VAL: begin
            if (lit_is_true) ev_sat_in = 1'b1;
            if (lit_is_true && ev_mag != cand_ff) ev_oth_in = 1'b1;
            ev_k_in = LW'(ev_k_ff + 1'b1);
            state_in = S_EV_LIT;
         end
         S_EV_END: begin
            idx_in = CW'(idx_ff + 1'b1);
            if (mode_brk_ff) begin
               if (ev_sat_ff && !ev_oth_ff) cnt_in = CW'(cnt_ff + 1'b1);
               state_in = S_BRK;
            end else begin
               if (!ev_sat_ff) begin
                  uns_we = 1'b1;
                  n_in = CW'(n_ff + 1'b1);
               end
               state_in = S_GATH;
            end
         end
         S_DRD: state_in = (bit_ff == 7'd64) ? S_DOUT : S_DRDW;
         S_DRDW: begin
            word_in[bit_ff[5:0]] = dump_ok && asg_rd_ff;
            bit_in = 7'(bit_ff + 1'b1);
            state_in = S_DRD;
         end
         S_DOUT: begin
            rsp_strobe_in = 1'b1;
            rsp_status_in = ST_SAT;
            rsp_word_in = word_ff;
            rsp_widx_in = w_ff;
            rsp_last_in = (w_ff == last_w);
            if (w_ff == last_w) begin
               state_in = S_IDLE;
            end else begin
               w_in = 2'(w_ff + 1'b1);
               bit_in = '0;
               word_in = '0;
               state_in = S_DRD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         num_vars_ff <= RST_NUM_VARS;
         num_clauses_ff <= RST_NUM_CLAUSES;
         max_tries_ff <= RST_MAX_TRIES;
         max_flips_ff <= RST_MAX_FLIPS;
         noise_ff <= RST_NOISE;
         rng_ff <= RST_SEED;
         load_cnt_ff <= '0;
         load_fill_ff <= '0;
         load_err_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         num_vars_ff <= num_vars_in;
         num_clauses_ff <= num_clauses_in;
         max_tries_ff <= max_tries_in;
         max_flips_ff <= max_flips_in;
         noise_ff <= noise_in;
         rng_ff <= rng_in;
         load_cnt_ff <= load_cnt_in;
         load_fill_ff <= load_fill_in;
         load_err_ff <= load_err_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      m_ff <= m_in;
      idx_ff <= idx_in;
      n_ff <= n_in;
      cnt_ff <= cnt_in;
      best_ff <= best_in;
      try_ff <= try_in;
      flip_ff <= flip_in;
      vctr_ff <= vctr_in;
      cand_ff <= cand_in;
      var_ff <= var_in;
      cur_c_ff <= cur_c_in;
      cur_len_ff <= cur_len_in;
      k2_ff <= k2_in;
      ev_len_ff <= ev_len_in;
      ev_k_ff <= ev_k_in;
      ev_sat_ff <= ev_sat_in;
      ev_oth_ff <= ev_oth_in;
      mode_brk_ff <= mode_brk_in;
      div_walk_ff <= div_walk_in;
      lit_ff <= lit_in;
      div_q_ff <= div_q_in;
      div_rem_ff <= div_rem_in;
      div_d_ff <= div_d_in;
      div_cnt_ff <= div_cnt_in;
      w_ff <= w_in;
      bit_ff <= bit_in;
      word_ff <= word_in;
      rsp_status_ff <= rsp_status_in;
      rsp_word_ff <= rsp_word_in;
      rsp_widx_ff <= rsp_widx_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_model_word = rsp_word_ff;
   assign rsp_word_index = rsp_widx_ff;
   assign rsp_last       = rsp_last_ff;

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != ST_SAT) |-> rsp_last)
      else $error("non-sat response without last");

   a_start_reacts: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_action) |=> (rsp_strobe || busy))
      else $error("start request neither answered nor running");

   a_rng_nonzero: assert property (@(posedge clock) disable iff (reset)
      rng_ff != '0)
      else $error("generator state reached zero");

endmodule

@@ tb/sv/tb_walksat_local_search_engine_top.sv @@
// tb_walksat_local_search_engine_top: self-checking bench for the local search engine,
// with a clocked driver, a monitor and a built-in predictor of the load and search.
// Depends on wsat_pkg and walksat_local_search_engine_top.
module tb_walksat_local_search_engine_top;
   import wsat_pkg::*;

   typedef struct {
      bit              action;
      logic [LIT_W-1:0] lit;
   } request_type;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [63:0]         word;
      logic [1:0]          index;
      logic                last;
   } response_type;

   logic                    clock = 0;
   logic                    reset = 1;
   logic                    start = 0;
   logic                    busy;
   logic                    req_action = 0;
   logic signed [LIT_W-1:0] req_literal = '0;
   logic                    rsp_strobe;
   logic [STATUS_W-1:0]     rsp_status;
   logic [63:0]             rsp_model_word;
   logic [1:0]              rsp_word_index;
   logic                    rsp_last;
   logic                    csr_we = 0;
   logic [CSR_IDX_W-1:0]    csr_index = CSR_NUM_VARS;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   walksat_local_search_engine_top DUT (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   request_type  pending_req[$];
   response_type expected_rsp[$];
   int        errors = 0;
   int        accepted = 0;

   // predictor state
   int        lit_mem[1024][8];
   int        len_mem[1024];
   bit        asg[257];
   int        unsat_idx[1024];
   int        clause_cnt = 0;
   int        fill_pos = 0;
   bit        load_err = 0;
   bit [31:0] rng_st = RST_SEED;
   int        nv_r = RST_NUM_VARS;
   int        nc_r = RST_NUM_CLAUSES;
   int        tries_r = RST_MAX_TRIES;
   int        flips_r = RST_MAX_FLIPS;
   int        noise_r = RST_NOISE;

   function automatic bit [31:0] rng_draw();
      bit [31:0] x;
      x = rng_st;
      x = x ^ (x << 13);
      x = x ^ (x >> 17);
      x = x ^ (x << 5);
      rng_st = x;
      return x;
   endfunction

   function automatic int active_vars();
      return nv_r > 256 ? 256 : nv_r;
   endfunction

   function automatic int mag(int l);
      return l < 0 ? -l : l;
   endfunction

   function automatic bit var_val(int v);
      if (v == 0 || v > active_vars()) return 0;
      return asg[v];
   endfunction

   function automatic bit lit_holds(int l);
      bit val;
      val = var_val(mag(l));
      return l > 0 ? val : !val;
   endfunction

   function automatic bit clause_holds(int c);
      for (int k = 0; k < len_mem[c]; k++)
         if (lit_holds(lit_mem[c][k])) return 1;
      return 0;
   endfunction

   function automatic int breaks_of(int v, int m);
      int cnt;
      bit brk;
      cnt = 0;
      for (int j = 0; j < m; j++) begin
         if (clause_holds(j)) begin
            brk = 1;
            for (int k = 0; k < len_mem[j]; k++)
               if (mag(lit_mem[j][k]) != v && lit_holds(lit_mem[j][k])) begin
                  brk = 0;
                  break;
               end
            if (brk) cnt++;
         end
      end
      return cnt;
   endfunction

   function automatic logic [STATUS_W-1:0] walk_search();
      int nv, m, n, c, len, v, best, b, cand;
      bit [31:0] x;
      nv = active_vars();
      m = clause_cnt;
      for (int t = 0; t < tries_r; t++) begin
         for (int i = 1; i <= nv; i++) begin
            x = rng_draw();
            asg[i] = x[0];
         end
         for (int f = 0; f < flips_r; f++) begin
            n = 0;
            for (int j = 0; j < m; j++)
               if (!clause_holds(j)) begin
                  unsat_idx[n] = j;
                  n++;
               end
            if (n == 0) return ST_SAT;
            c = unsat_idx[rng_draw() % n];
            len = len_mem[c];
            if ((rng_draw() & 32'hFFFF) < noise_r) begin
               v = mag(lit_mem[c][rng_draw() % len]);
            end else begin
               v = mag(lit_mem[c][0]);
               best = m;
               for (int k = 0; k < len; k++) begin
                  cand = mag(lit_mem[c][k]);
                  b = breaks_of(cand, m);
                  if (b < best) begin
                     best = b;
                     v = cand;
                  end
               end
            end
            if (v >= 1 && v <= nv) asg[v] = !asg[v];
         end
      end
      return ST_OUT_OF_TIME;
   endfunction

   function automatic void predict_request(bit action, logic [LIT_W-1:0] raw);
      int lit, cap, words;
      logic [STATUS_W-1:0] st;
      response_type r;
      lit = $signed(raw);
      st = ST_ACCEPTED;
      if (!action) begin
         cap = nc_r < 1024 ? nc_r : 1024;
         if (lit == 0) begin
            if (fill_pos > 0) begin
               len_mem[clause_cnt] = fill_pos;
               clause_cnt++;
               fill_pos = 0;
            end
         end else if (clause_cnt >= cap) begin
            st = ST_TOO_MANY;
            load_err = 1;
         end else if (fill_pos >= 8) begin
            st = ST_TOO_LONG;
            load_err = 1;
         end else begin
            lit_mem[clause_cnt][fill_pos] = lit;
            fill_pos++;
         end
      end else begin
         if (load_err || fill_pos != 0 || clause_cnt != nc_r) st = ST_MISMATCH;
         else st = walk_search();
         clause_cnt = 0;
         fill_pos = 0;
         load_err = 0;
         if (st == ST_SAT) begin
            words = (active_vars() + 63) / 64;
            if (words == 0) words = 1;
            for (int w = 0; w < words; w++) begin
               r.status = ST_SAT;
               r.word = '0;
               for (int i = 0; i < 64; i++) r.word[i] = var_val(w * 64 + i + 1);
               r.index = 2'(w);
               r.last = (w + 1 == words);
               expected_rsp.push_back(r);
            end
            return;
         end
      end
      r.status = st;
      r.word = '0;
      r.index = '0;
      r.last = 1;
      expected_rsp.push_back(r);
   endfunction

   // driver
   always @(posedge clock) begin
      request_type nxt;
      bit       idle;
      if (reset) begin
         start <= 0;
      end else if (!(start && busy)) begin
         if (start) begin
            predict_request(req_action, req_literal);
            accepted++;
         end
         idle = (accepted < 100 || accepted > 180) && ($urandom_range(0, 99) < 25);
         if (pending_req.size() > 0 && !idle) begin
            nxt = pending_req.pop_front();
            start <= 1;
            req_action <= nxt.action;
            req_literal <= nxt.lit;
         end else begin
            start <= 0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      response_type e;
      if (!reset && rsp_strobe) begin
         if (expected_rsp.size() == 0) begin
            $error("unexpected response status %0d", rsp_status);
            errors++;
         end else begin
            e = expected_rsp.pop_front();
            if (rsp_status !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_status);
               errors++;
            end
            if (rsp_model_word !== e.word) begin
               $error("model_word expected %h actual %h", e.word, rsp_model_word);
               errors++;
            end
            if (rsp_word_index !== e.index) begin
               $error("word_index expected %0d actual %0d", e.index, rsp_word_index);
               errors++;
            end
            if (rsp_last !== e.last) begin
               $error("last expected %0d actual %0d", e.last, rsp_last);
               errors++;
            end
         end
      end
   end

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      case (idx)
         CSR_NUM_VARS:    nv_r = val[8:0];
         CSR_NUM_CLAUSES: nc_r = val[10:0];
         CSR_MAX_TRIES:   tries_r = val[15:0];
         CSR_MAX_FLIPS:   flips_r = val[19:0];
         CSR_NOISE:       noise_r = val[15:0];
         CSR_SEED:        rng_st = (val == 0) ? 32'd1 : val;
         default: ;
      endcase
   endtask

   task automatic set_cfg(int nv, int nc, int tr, int fl, int no, logic [31:0] sd);
      csr_write(CSR_NUM_VARS, nv);
      csr_write(CSR_NUM_CLAUSES, nc);
      csr_write(CSR_MAX_TRIES, tr);
      csr_write(CSR_MAX_FLIPS, fl);
      csr_write(CSR_NOISE, no);
      csr_write(CSR_SEED, sd);
   endtask

   task automatic push_req(bit action, int lit);
      request_type r;
      r.action = action;
      r.lit = LIT_W'(lit);
      pending_req.push_back(r);
   endtask

   task automatic drain();
      do @(posedge clock);
      while (pending_req.size() > 0 || start || expected_rsp.size() > 0);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      int total, m, len, nv, lit;
      repeat (11) @(posedge clock);
      reset <= 0;
      // reset defaults, stray zero, single clause
      push_req(0, 0);
      push_req(0, 1);
      push_req(0, 0);
      push_req(1, 0);
      drain();
      // no variables: out of range literal never true
      set_cfg(0, 1, 5, 100, 37355, 32'h0);
      push_req(0, 1); push_req(0, 0); push_req(1, 0);
      drain();
      // saturated variable count, four model words, far literals
      set_cfg(300, 2, 2, 10, 0, 32'h0);
      push_req(0, 256); push_req(0, -256); push_req(0, 0);
      push_req(0, -512); push_req(0, 511); push_req(0, 0); push_req(0, 0);
      push_req(1, 0);
      drain();
      // no clause room
      set_cfg(4, 0, 1, 1, 65535, 32'hFFFF_FFFF);
      push_req(0, 5); push_req(1, 0);
      drain();
      // clause too long, then open clause, then count mismatch
      set_cfg(8, 1, 1, 1, 100, 32'h1234_5678);
      for (int k = 1; k <= 9; k++) push_req(0, k);
      push_req(0, 0); push_req(1, 0);
      push_req(0, 2); push_req(1, 0);
      drain();
      set_cfg(8, 2, 0, 5, 100, 32'h5);
      push_req(0, 3); push_req(0, 0); push_req(1, 0);
      drain();
      // zero tries, zero flips
      set_cfg(2, 2, 0, 5, 100, 32'h9);
      push_req(0, 1); push_req(0, 0); push_req(0, -1); push_req(0, 0); push_req(1, 0);
      drain();
      set_cfg(2, 2, 3, 0, 100, 32'h9);
      push_req(0, 1); push_req(0, 0); push_req(0, -1); push_req(0, 0); push_req(1, 0);
      drain();
      // large limits on a tautology
      set_cfg(3, 1, 65535, 1048575, 65535, 32'hFFFF_FFFF);
      push_req(0, 3); push_req(0, -3); push_req(0, 0); push_req(1, 0);
      drain();

      total = 0;
      while (total < 262) begin
         nv = ($urandom_range(0, 9) == 0) ? $urandom_range(129, 256) : $urandom_range(1, 70);
         m = $urandom_range(1, 5);
         set_cfg(nv, m, $urandom_range(1, 2), $urandom_range(1, 20),
                 $urandom_range(0, 65535), $urandom());
         for (int c = 0; c < m; c++) begin
            len = $urandom_range(1, 4);
            for (int k = 0; k < len; k++) begin
               lit = $urandom_range(1, nv);
               push_req(0, $urandom_range(0, 1) ? lit : -lit);
               total++;
            end
            push_req(0, 0);
            total++;
         end
         case ($urandom_range(0, 9))
            0: begin
               push_req(0, $urandom_range(0, 1023));
               total++;
            end
            1: begin
               for (int k = 0; k < 9; k++)
                  push_req(1'($urandom_range(0, 1)), $urandom_range(0, 1023));
               total += 9;
            end
            2: begin
               push_req(0, 0);
               total++;
            end
            default: ;
         endcase
         push_req(1, $urandom_range(0, 1023));
         total++;
         drain();
      end

      drain();
      repeat (300) @(posedge clock);
      if (errors == 0 && expected_rsp.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #40000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

@@ files.f @@
design/wsat_pkg.sv
design/walksat_local_search_engine_top.sv
tb/sv/tb_walksat_local_search_engine_top.sv
